/* sv/window_gradient_coherence_unit_macros.svh */
// Assertion macros shared by the window gradient coherence RTL.
`ifndef WINDOW_GRADIENT_COHERENCE_UNIT_MACROS_SVH
`define WINDOW_GRADIENT_COHERENCE_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define WGC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define WGC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/wgc_pkg.sv */
// Package with widths, types and the arctangent table of the coherence unit.
`timescale 1ns / 1ps
package wgc_pkg;
   localparam int EDGE_W       = 12;
   localparam int WIN_W        = 6;
   localparam int SUM_WIDTH    = 37;
   localparam int SQ_W         = SUM_WIDTH - 1;
   localparam int ANGLE_BITS   = 16;
   localparam int MAG_W        = SUM_WIDTH + 1;
   localparam int HALF_W       = (MAG_W + 1) / 2;
   localparam int PP_W         = 2 * HALF_W;
   localparam int SQR_W        = 2 * MAG_W;
   localparam int CMP_W        = SQR_W + 8;
   localparam int CV_W         = SUM_WIDTH + 4;
   localparam int Z_W          = 34;
   localparam int CORDIC_STEPS = 31;
   localparam int RSH          = 33 - ANGLE_BITS;
   localparam int COH_STAGES   = 6;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5);

   localparam logic signed [Z_W-1:0] PI_UNITS = Z_W'(64'h80000000);
   localparam logic signed [Z_W-1:0] ANG_LIM  = Z_W'(64'd1 << (ANGLE_BITS - 2));
   localparam logic signed [Z_W-1:0] ANG_RND  = Z_W'(64'd1 << (32 - ANGLE_BITS));

   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      34'h020000000, 34'h012E4051E, 34'h009FB385B, 34'h0051111D4,
      34'h0028B0D43, 34'h00145D7E1, 34'h000A2F61E, 34'h000517C55,
      34'h00028BE53, 34'h000145F2F, 34'h0000A2F98, 34'h0000517CC,
      34'h000028BE6, 34'h0000145F3, 34'h00000A2FA, 34'h00000517D,
      34'h0000028BE, 34'h00000145F, 34'h000000A30, 34'h000000518,
      34'h00000028C, 34'h000000146, 34'h0000000A3, 34'h000000051,
      34'h000000029, 34'h000000014, 34'h00000000A, 34'h000000005,
      34'h000000003, 34'h000000001, 34'h000000001
   };

   // Control that travels with each item.
   typedef struct packed {
      logic              valid;
      logic              keep;
      logic [EDGE_W-1:0] edges;
   } wgc_tag_type;

   // Rotation vector and angle accumulator.
   typedef struct packed {
      logic signed [CV_W-1:0] x;
      logic signed [CV_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } wgc_vec_type;
endpackage

/* sv/wgc_if.sv */
// Valid/ready channel interfaces for window sums and window results.
`timescale 1ns / 1ps
interface wgc_req_if;
   logic                                valid;
   logic                                ready;
   logic [wgc_pkg::EDGE_W-1:0]          edge_count;
   logic [wgc_pkg::SQ_W-1:0]            sum_xx;
   logic [wgc_pkg::SQ_W-1:0]            sum_yy;
   logic signed [wgc_pkg::SUM_WIDTH-1:0] sum_xy;
   modport source (output valid, edge_count, sum_xx, sum_yy, sum_xy, input ready);
   modport sink (input valid, edge_count, sum_xx, sum_yy, sum_xy, output ready);
endinterface

interface wgc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 coherent;
   logic signed [wgc_pkg::ANGLE_BITS-1:0] orientation;
   logic [wgc_pkg::EDGE_W-1:0]           edge_total;
   modport source (output valid, coherent, orientation, edge_total, input ready);
   modport sink (input valid, coherent, orientation, edge_total, output ready);
endinterface

/* sv/wgc_coh.sv */
// Coherence and area test pipeline, with CORDIC start vector set up alongside.
`timescale 1ns / 1ps
module wgc_coh (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [wgc_pkg::WIN_W-1:0]         win_side,
   input  logic                              in_valid,
   input  logic [wgc_pkg::EDGE_W-1:0]        edge_count,
   input  logic [wgc_pkg::SQ_W-1:0]          sum_xx,
   input  logic [wgc_pkg::SQ_W-1:0]          sum_yy,
   input  logic signed [wgc_pkg::SUM_WIDTH-1:0] sum_xy,
   output wgc_pkg::wgc_tag_type              tag_out,
   output wgc_pkg::wgc_vec_type              vec_out
);
   import wgc_pkg::*;

   logic [COH_STAGES-1:0] valid_ff;
   logic [EDGE_W-1:0]     edges_ff [COH_STAGES];
   logic                  area_ff  [COH_STAGES];
   wgc_vec_type           vec_ff   [COH_STAGES];

   logic signed [SUM_WIDTH-1:0] diff;
   logic signed [MAG_W-1:0]     twoxy;
   logic [18:0]                 edge_scaled;
   logic [18:0]                 area_thr;
   logic                        area_in;
   logic [MAG_W-1:0]            mag_in [3];
   wgc_vec_type                 vec_in;

   logic [MAG_W-1:0] mag_ff [3];
   logic [PP_W-1:0]  hh_ff  [3];
   logic [PP_W-1:0]  hl_ff  [3];
   logic [PP_W-1:0]  ll_ff  [3];
   logic [SQR_W-1:0] sq_ff  [3];
   logic [CMP_W-1:0] energy_ff, s2_ff, lhs_ff, rhs_ff;
   logic             keep_ff;

   // First stage: difference, doubled cross term, magnitudes and area test.
   always_comb begin
      diff        = $signed({1'b0, sum_xx}) - $signed({1'b0, sum_yy});
      twoxy       = {sum_xy, 1'b0};
      edge_scaled = 19'(edge_count) * 19'd100;
      area_thr    = 19'd42 * 19'(12'(win_side) * 12'(win_side));
      area_in     = edge_scaled >= area_thr;
      mag_in[0]   = diff[SUM_WIDTH-1] ? MAG_W'(-MAG_W'(diff)) : MAG_W'(diff);
      mag_in[1]   = twoxy[MAG_W-1] ? MAG_W'(-twoxy) : MAG_W'(twoxy);
      mag_in[2]   = MAG_W'(sum_xx) + MAG_W'(sum_yy);
      // Fold the left half plane onto the right and preload plus or minus pi.
      if (twoxy[MAG_W-1]) begin
         vec_in.x = -CV_W'(twoxy);
         vec_in.y = -CV_W'(diff);
         vec_in.z = diff[SUM_WIDTH-1] ? -PI_UNITS : PI_UNITS;
      end else begin
         vec_in.x = CV_W'(twoxy);
         vec_in.y = CV_W'(diff);
         vec_in.z = '0;
      end
   end

   // Valid bits advance together with the payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[COH_STAGES-2:0], in_valid};
      end
   end

   // Side payload carried through every stage.
   always_ff @(posedge clock) begin
      if (en) begin
         edges_ff[0] <= edge_count;
         area_ff[0]  <= area_in;
         vec_ff[0]   <= vec_in;
         for (int k = 1; k < COH_STAGES; k++) begin
            edges_ff[k] <= edges_ff[k-1];
            area_ff[k]  <= area_ff[k-1];
            vec_ff[k]   <= vec_ff[k-1];
         end
      end
   end

   // Squares in four steps: half-width partial products, recombination,
   // energy sum, constant scaling; then the compare.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mag_ff[k] <= mag_in[k];
            hh_ff[k]  <= PP_W'(mag_ff[k][MAG_W-1:HALF_W]) * PP_W'(mag_ff[k][MAG_W-1:HALF_W]);
            hl_ff[k]  <= PP_W'(mag_ff[k][MAG_W-1:HALF_W]) * PP_W'(mag_ff[k][HALF_W-1:0]);
            ll_ff[k]  <= PP_W'(mag_ff[k][HALF_W-1:0]) * PP_W'(mag_ff[k][HALF_W-1:0]);
            sq_ff[k]  <= (SQR_W'(hh_ff[k]) << (2 * HALF_W)) +
                         (SQR_W'(hl_ff[k]) << (HALF_W + 1)) + SQR_W'(ll_ff[k]);
         end
         energy_ff <= CMP_W'(sq_ff[0]) + CMP_W'(sq_ff[1]);
         s2_ff     <= CMP_W'(sq_ff[2]);
         lhs_ff    <= energy_ff * CMP_W'(100);
         rhs_ff    <= s2_ff * CMP_W'(81);
         keep_ff   <= area_ff[COH_STAGES-2] && (lhs_ff > rhs_ff);
      end
   end

   assign tag_out.valid = valid_ff[COH_STAGES-1];
   assign tag_out.keep  = keep_ff;
   assign tag_out.edges = edges_ff[COH_STAGES-1];
   assign vec_out       = vec_ff[COH_STAGES-1];
endmodule

/* sv/wgc_cordic.sv */
// CORDIC vectoring pipeline, one rotation per stage, with final rounding.
`timescale 1ns / 1ps
module wgc_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  wgc_pkg::wgc_tag_type                tag_in,
   input  wgc_pkg::wgc_vec_type                vec_in,
   output logic                                out_valid,
   output logic                                coherent,
   output logic signed [wgc_pkg::ANGLE_BITS-1:0] orientation,
   output logic [wgc_pkg::EDGE_W-1:0]          edge_total
);
   import wgc_pkg::*;

   wgc_tag_type tag_ff [CORDIC_STEPS];
   wgc_vec_type vec_ff [CORDIC_STEPS];
   wgc_vec_type step_in [CORDIC_STEPS];

   logic signed [Z_W-1:0]        z_round;
   logic signed [Z_W-1:0]        z_clamp;
   logic                         out_valid_ff, coherent_ff;
   logic signed [ANGLE_BITS-1:0] orientation_ff, orientation_in;
   logic [EDGE_W-1:0]            edge_total_ff;

   // One micro-rotation per stage; shifts are arithmetic (floor).
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      wgc_vec_type src;
      if (i == 0) begin : g_first
         assign src = vec_in;
      end else begin : g_next
         assign src = vec_ff[i-1];
      end
      always_comb begin
         if (!src.y[CV_W-1]) begin
            step_in[i].x = src.x + (src.y >>> i);
            step_in[i].y = src.y - (src.x >>> i);
            step_in[i].z = src.z + ATAN_TAB[i];
         end else begin
            step_in[i].x = src.x - (src.y >>> i);
            step_in[i].y = src.y + (src.x >>> i);
            step_in[i].z = src.z - ATAN_TAB[i];
         end
      end
   end

   // Stage registers; valid bits are the only reset state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            vec_ff[k] <= step_in[k];
         end
      end
   end

   // Round half up to the output scale and clamp to a half turn.
   always_comb begin
      z_round = (vec_ff[CORDIC_STEPS-1].z + ANG_RND) >>> RSH;
      if (z_round > ANG_LIM) begin
         z_clamp = ANG_LIM;
      end else if (z_round < -ANG_LIM) begin
         z_clamp = -ANG_LIM;
      end else begin
         z_clamp = z_round;
      end
      orientation_in = tag_ff[CORDIC_STEPS-1].keep ? ANGLE_BITS'(z_clamp) : '0;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= tag_ff[CORDIC_STEPS-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coherent_ff    <= tag_ff[CORDIC_STEPS-1].keep;
         orientation_ff <= orientation_in;
         edge_total_ff  <= tag_ff[CORDIC_STEPS-1].keep ? tag_ff[CORDIC_STEPS-1].edges : '0;
      end
   end

   assign out_valid   = out_valid_ff;
   assign coherent    = coherent_ff;
   assign orientation = orientation_ff;
   assign edge_total  = edge_total_ff;
endmodule

/* sv/window_gradient_coherence_unit.sv */
// Top level of the window gradient coherence unit.
//
// Use: present one window's box sums (edge_count, sum_xx, sum_yy, sum_xy) on
// the req_ch channel; one result (coherent, orientation, edge_total) leaves on
// rsp_ch for every item taken, in order. Both channels move an item on a
// clock edge where valid and ready are high.
// The user must write the window side (csr_we/csr_wdata) only while the unit
// is idle; the block itself does not enforce this. The pipeline has 38
// register stages. Six stages hold the area and root-free coherence test
// (magnitudes, split squares, recombine, sum, scale, compare), 31 the CORDIC
// rotations, and the last the rounding output. Throughput is one item per
// cycle unless rsp_ch stalls; the CORDIC rotation chain sets the depth.
// When rsp_ch stalls with a result waiting, the whole pipeline holds and
// req_ch.ready drops; an empty output stage keeps the pipeline moving.
// Reset clears all stage valid bits and sets the window side to 5; there is
// no clearing pass and the unit takes items the cycle after reset falls.
`timescale 1ns / 1ps
`include "window_gradient_coherence_unit_macros.svh"
module window_gradient_coherence_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [wgc_pkg::WIN_W-1:0]   csr_wdata,
   wgc_req_if.sink                     req_ch,
   wgc_rsp_if.source                   rsp_ch
);
   import wgc_pkg::*;

   logic              en;
   logic [WIN_W-1:0]  win_side_ff;
   wgc_tag_type       coh_tag;
   wgc_vec_type       coh_vec;

   // Window side register.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_side_ff <= WIN_RESET;
      end else if (csr_we) begin
         win_side_ff <= csr_wdata;
      end
   end

   // The pipeline advances unless a result waits on a stalled receiver.
   assign en           = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = en;

   wgc_coh u_coh (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .win_side    (win_side_ff),
      .in_valid    (req_ch.valid),
      .edge_count  (req_ch.edge_count),
      .sum_xx      (req_ch.sum_xx),
      .sum_yy      (req_ch.sum_yy),
      .sum_xy      (req_ch.sum_xy),
      .tag_out     (coh_tag),
      .vec_out     (coh_vec)
   );

   wgc_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .tag_in      (coh_tag),
      .vec_in      (coh_vec),
      .out_valid   (rsp_ch.valid),
      .coherent    (rsp_ch.coherent),
      .orientation (rsp_ch.orientation),
      .edge_total  (rsp_ch.edge_total)
   );

   // A rejected window reports all zeros.
   `WGC_ASSERT_NOW(a_reject_zero, rsp_ch.valid && !rsp_ch.coherent,
      rsp_ch.orientation == '0 && rsp_ch.edge_total == '0, "rejected window not zeroed")
   // The angle stays within a half turn.
   `WGC_ASSERT_NOW(a_angle_range, rsp_ch.valid,
      rsp_ch.orientation <= ANGLE_BITS'(ANG_LIM) && rsp_ch.orientation >= -ANGLE_BITS'(ANG_LIM),
      "orientation out of range")
   // An empty output stage never blocks the input.
   `WGC_ASSERT_NOW(a_no_false_stall, !rsp_ch.valid, req_ch.ready, "input blocked while empty")
   // Without a write the window side holds its value.
   `WGC_ASSERT_NEXT(a_cfg_hold, !csr_we, win_side_ff == $past(win_side_ff),
      "window size changed without a write")
endmodule
